FILE: rtl/fel_pkg.sv
`timescale 1ns / 1ps
// Package for the frame element local force pipeline: widths, register
// indexes, item and stage structs, and the quotient saturation function.
// No dependencies.
package fel_pkg;

    // Field widths of the stream items and configuration registers
    localparam int TAG_W       = 10;
    localparam int LEN_W       = 24;
    localparam int DISP_W      = 32;
    localparam int RES_W       = 48;
    localparam int E_W         = 40;
    localparam int A_W         = 32;
    localparam int I_W         = 32;
    localparam int C_W         = 16;
    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 400;
    localparam int OUT_PAD_W   = OUT_TDATA_W - TAG_W - 8 * RES_W;
    localparam int NUM_RES     = 6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_ELASTIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIBER   = 2'd3;

    localparam logic [E_W-1:0] RST_ELASTIC = '0;
    localparam logic [A_W-1:0] RST_AREA    = 32'd10000;
    localparam logic [I_W-1:0] RST_INERTIA = 32'd10000;
    localparam logic [C_W-1:0] RST_FIBER   = 16'd10;

    // Front-end intermediate widths
    localparam int DU_W   = DISP_W + 1;
    localparam int RA_W   = DISP_W + 3;
    localparam int DV12_W = 48;
    localparam int TERM_W = 61;
    localparam int MAG_W  = 60;
    localparam int DAX_W  = 44;
    localparam int L2_W   = 2 * LEN_W;
    localparam int L3_W   = 3 * LEN_W;
    localparam int DMO_W  = 78;
    localparam int DSH_W  = 82;
    localparam int C6_W   = 36;

    localparam int K_SHEAR_DV  = 12000;
    localparam int K_MOMENT_DV = 6000;
    localparam int K_AX_DEN    = 1000000;
    localparam int K_MO_DEN    = 1000000000;
    localparam int K_SH_DEN    = 1000;
    localparam int K_MILLI     = 1000;
    localparam int K_FIBER     = 1000000;

    // Wide multiplier, split into four partial products
    localparam int MUL_A_W  = 72;
    localparam int MUL_B_W  = 64;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int MUL_AL_W = MUL_A_W / 2;
    localparam int MUL_BL_W = MUL_B_W / 2;
    localparam int MUL_PP_W = MUL_AL_W + MUL_BL_W;

    // Restoring divider
    localparam int NUM_W   = MUL_P_W;
    localparam int DEN_W   = DSH_W;
    localparam int Q_W     = RES_W;
    localparam int HI_W    = NUM_W - Q_W;
    localparam int DIV_LAT = Q_W + 1;

    localparam logic [RES_W-1:0] SAT_HI = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] SAT_LO = {1'b1, {(RES_W-1){1'b0}}};

    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic [LEN_W-1:0]         len;
        logic signed [DISP_W-1:0] ai;
        logic signed [DISP_W-1:0] vi;
        logic signed [DISP_W-1:0] ri;
        logic signed [DISP_W-1:0] aj;
        logic signed [DISP_W-1:0] vj;
        logic signed [DISP_W-1:0] rj;
    } t_item;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [DAX_W-1:0] dax;
        logic [DMO_W-1:0] dmo;
        logic [DSH_W-1:0] dsh;
        logic [DU_W-1:0]  mag_du;
        logic [MAG_W-1:0] mag_sh;
        logic [MAG_W-1:0] mag_mi;
        logic [MAG_W-1:0] mag_mj;
        logic             neg_du;
        logic             neg_sh;
        logic             neg_mi;
        logic             neg_mj;
    } t_front;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic             neg_du;
        logic             neg_sh;
        logic             neg_mi;
        logic             neg_mj;
    } t_side1;

    typedef struct packed {
        logic                            valid;
        logic [TAG_W-1:0]                tag;
        logic [NUM_RES-1:0][RES_W-1:0]   res;
        logic                            flag;
        logic                            neg_t1;
        logic                            neg_t2;
    } t_side2;

    typedef struct packed {
        logic             flag;
        logic [RES_W-1:0] val;
    } t_sat;

    // Signs a quotient magnitude and clips it to the 48-bit range. A zero
    // divisor always raises the flag.
    function automatic t_sat sat_quo(input logic [Q_W-1:0] q, input logic big,
                                     input logic dz, input logic neg);
        t_sat r;
        logic clip;
        if (neg) begin
            clip = big | (q[Q_W-1] & (|q[Q_W-2:0]));
        end else begin
            clip = big | q[Q_W-1];
        end
        if (clip) begin
            r.val = neg ? SAT_LO : SAT_HI;
        end else begin
            r.val = neg ? (RES_W'(0) - q) : q;
        end
        r.flag = clip | dz;
        return r;
    endfunction

endpackage

FILE: rtl/fel_mul.sv
`timescale 1ns / 1ps
// Two-stage unsigned 72x64 multiplier built from four registered partial
// products. Depends on fel_pkg.
module fel_mul (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fel_pkg::MUL_A_W-1:0] i_a,
    input  logic [fel_pkg::MUL_B_W-1:0] i_b,
    output logic [fel_pkg::MUL_P_W-1:0] o_p
);
    import fel_pkg::*;

    logic [MUL_PP_W-1:0] r_pp_ll;
    logic [MUL_PP_W-1:0] r_pp_lh;
    logic [MUL_PP_W-1:0] r_pp_hl;
    logic [MUL_PP_W-1:0] r_pp_hh;
    logic [MUL_P_W-1:0]  r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_ll <= MUL_PP_W'(i_a[MUL_AL_W-1:0]) * MUL_PP_W'(i_b[MUL_BL_W-1:0]);
            r_pp_lh <= MUL_PP_W'(i_a[MUL_AL_W-1:0]) * MUL_PP_W'(i_b[MUL_B_W-1:MUL_BL_W]);
            r_pp_hl <= MUL_PP_W'(i_a[MUL_A_W-1:MUL_AL_W]) * MUL_PP_W'(i_b[MUL_BL_W-1:0]);
            r_pp_hh <= MUL_PP_W'(i_a[MUL_A_W-1:MUL_AL_W]) * MUL_PP_W'(i_b[MUL_B_W-1:MUL_BL_W]);
            r_p     <= MUL_P_W'(r_pp_ll)
                     + (MUL_P_W'(r_pp_lh) << MUL_BL_W)
                     + (MUL_P_W'(r_pp_hl) << MUL_AL_W)
                     + (MUL_P_W'(r_pp_hh) << MUL_PP_W);
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/fel_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one range check stage, then one quotient bit
// per stage. Quotients of 2^48 or more are reported as big. Depends on fel_pkg.
module fel_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [fel_pkg::NUM_W-1:0] i_num,
    input  logic [fel_pkg::DEN_W-1:0] i_den,
    output logic [fel_pkg::Q_W-1:0]   o_quo,
    output logic                      o_big,
    output logic                      o_dz
);
    import fel_pkg::*;

    logic [DEN_W-1:0] r_rem [Q_W+1];
    logic [DEN_W-1:0] r_den [Q_W+1];
    logic [Q_W-1:0]   r_low [Q_W+1];
    logic [Q_W-1:0]   r_quo [Q_W+1];
    logic             r_big [Q_W+1];
    logic             r_dz  [Q_W+1];

    logic            n_dz;
    logic            n_big;
    logic [HI_W-1:0] n_hi;

    // The quotient fits in 48 bits exactly when the numerator's upper part
    // is below the divisor. A zero divisor is swapped for all ones with a
    // zero numerator so that the steps yield a zero quotient.
    always_comb begin
        n_hi  = i_num[NUM_W-1:Q_W];
        n_dz  = (i_den == '0);
        n_big = n_dz ? (|i_num) : (n_hi >= HI_W'(i_den));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_dz ? '0 : n_hi[DEN_W-1:0];
            r_den[0] <= n_dz ? '1 : i_den;
            r_low[0] <= n_dz ? '0 : i_num[Q_W-1:0];
            r_quo[0] <= '0;
            r_big[0] <= n_big;
            r_dz[0]  <= n_dz;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [DEN_W:0] n_sh;
        logic           n_ge;
        logic [Q_W-1:0] n_q;

        always_comb begin
            n_sh         = {r_rem[k-1], r_low[k-1][Q_W-k]};
            n_ge         = (n_sh >= {1'b0, r_den[k-1]});
            n_q          = r_quo[k-1];
            n_q[Q_W-k]   = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? DEN_W'(n_sh - {1'b0, r_den[k-1]}) : DEN_W'(n_sh);
                r_den[k] <= r_den[k-1];
                r_low[k] <= r_low[k-1];
                r_quo[k] <= n_q;
                r_big[k] <= r_big[k-1];
                r_dz[k]  <= r_dz[k-1];
            end
        end
    end

    assign o_quo = r_quo[Q_W];
    assign o_big = r_big[Q_W];
    assign o_dz  = r_dz[Q_W];

endmodule

FILE: rtl/fel_front.sv
`timescale 1ns / 1ps
// Four-stage front end: differences, stiffness numerator terms and the
// length-power divisors, ending in magnitudes and signs. Depends on fel_pkg.
module fel_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  fel_pkg::t_item  i_item,
    output fel_pkg::t_front o_front
);
    import fel_pkg::*;

    // Stage 1
    logic                     r_s1_valid;
    logic [TAG_W-1:0]         r_s1_tag;
    logic [LEN_W-1:0]         r_s1_len;
    logic signed [DU_W-1:0]   r_s1_du;
    logic signed [DU_W-1:0]   r_s1_dv;
    logic signed [DU_W-1:0]   r_s1_rs;
    logic signed [RA_W-1:0]   r_s1_ra;
    logic signed [RA_W-1:0]   r_s1_rb;
    // Stage 2
    logic                     r_s2_valid;
    logic [TAG_W-1:0]         r_s2_tag;
    logic [LEN_W-1:0]         r_s2_len;
    logic signed [DU_W-1:0]   r_s2_du;
    logic signed [DV12_W-1:0] r_s2_dv12;
    logic signed [DV12_W-1:0] r_s2_dv6;
    logic signed [TERM_W-1:0] r_s2_lrs;
    logic signed [TERM_W-1:0] r_s2_lra;
    logic signed [TERM_W-1:0] r_s2_lrb;
    logic [L2_W-1:0]          r_s2_l2;
    logic [DAX_W-1:0]         r_s2_dax;
    // Stage 3
    logic                     r_s3_valid;
    logic [TAG_W-1:0]         r_s3_tag;
    logic signed [DU_W-1:0]   r_s3_du;
    logic signed [TERM_W-1:0] r_s3_sh;
    logic signed [TERM_W-1:0] r_s3_mi;
    logic signed [TERM_W-1:0] r_s3_mj;
    logic [L3_W-1:0]          r_s3_l3;
    logic [DMO_W-1:0]         r_s3_dmo;
    logic [DAX_W-1:0]         r_s3_dax;
    // Stage 4
    t_front                   r_s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4.valid <= r_s3_valid;

            r_s1_tag <= i_item.tag;
            r_s1_len <= i_item.len;
            r_s1_du  <= DU_W'(i_item.ai) - DU_W'(i_item.aj);
            r_s1_dv  <= DU_W'(i_item.vi) - DU_W'(i_item.vj);
            r_s1_rs  <= DU_W'(i_item.ri) + DU_W'(i_item.rj);
            r_s1_ra  <= (RA_W'(i_item.ri) <<< 2) + (RA_W'(i_item.rj) <<< 1);
            r_s1_rb  <= (RA_W'(i_item.ri) <<< 1) + (RA_W'(i_item.rj) <<< 2);

            r_s2_tag  <= r_s1_tag;
            r_s2_len  <= r_s1_len;
            r_s2_du   <= r_s1_du;
            r_s2_dv12 <= DV12_W'(r_s1_dv) * DV12_W'(K_SHEAR_DV);
            r_s2_dv6  <= DV12_W'(r_s1_dv) * DV12_W'(K_MOMENT_DV);
            r_s2_lrs  <= TERM_W'($signed({1'b0, r_s1_len})) * TERM_W'(r_s1_rs);
            r_s2_lra  <= TERM_W'($signed({1'b0, r_s1_len})) * TERM_W'(r_s1_ra);
            r_s2_lrb  <= TERM_W'($signed({1'b0, r_s1_len})) * TERM_W'(r_s1_rb);
            r_s2_l2   <= L2_W'(r_s1_len) * L2_W'(r_s1_len);
            r_s2_dax  <= DAX_W'(r_s1_len) * DAX_W'(K_AX_DEN);

            r_s3_tag <= r_s2_tag;
            r_s3_du  <= r_s2_du;
            r_s3_sh  <= TERM_W'(r_s2_dv12) + (r_s2_lrs <<< 2) + (r_s2_lrs <<< 1);
            r_s3_mi  <= TERM_W'(r_s2_dv6) + r_s2_lra;
            r_s3_mj  <= TERM_W'(r_s2_dv6) + r_s2_lrb;
            r_s3_l3  <= L3_W'(r_s2_l2) * L3_W'(r_s2_len);
            r_s3_dmo <= DMO_W'(r_s2_l2) * DMO_W'(K_MO_DEN);
            r_s3_dax <= r_s2_dax;

            r_s4.tag    <= r_s3_tag;
            r_s4.dax    <= r_s3_dax;
            r_s4.dmo    <= r_s3_dmo;
            r_s4.dsh    <= DSH_W'(r_s3_l3) * DSH_W'(K_SH_DEN);
            r_s4.mag_du <= r_s3_du[DU_W-1] ? DU_W'(-r_s3_du) : DU_W'(r_s3_du);
            r_s4.mag_sh <= MAG_W'(r_s3_sh[TERM_W-1] ? -r_s3_sh : r_s3_sh);
            r_s4.mag_mi <= MAG_W'(r_s3_mi[TERM_W-1] ? -r_s3_mi : r_s3_mi);
            r_s4.mag_mj <= MAG_W'(r_s3_mj[TERM_W-1] ? -r_s3_mj : r_s3_mj);
            r_s4.neg_du <= r_s3_du[DU_W-1];
            r_s4.neg_sh <= r_s3_sh[TERM_W-1];
            r_s4.neg_mi <= r_s3_mi[TERM_W-1];
            r_s4.neg_mj <= r_s3_mj[TERM_W-1];
        end
    end

    assign o_front = r_s4;

endmodule

FILE: rtl/frame_element_local_forces_top.sv
`timescale 1ns / 1ps
// Local end forces and fiber stresses of a 2D frame element, fully pipelined.
// Each input transfer passes through the front end, the multipliers and the two
// chained 49-stage dividers; an output stall holds the whole pipeline in place.
// Throughput: one element per cycle while the output is not stalled, since every
// stage is pipelined. Reset (synchronous, active low) clears all valid bits and loads the register defaults.
module frame_element_local_forces_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Config write port
    input  logic                            i_cfg_we,
    input  logic [fel_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fel_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: element_index, length_um, axial_i, transverse_i,
    // rotation_i, axial_j, transverse_j, rotation_j, zero pad
    input  logic [fel_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0: element_tag, force_axial_i, force_shear_i,
    // moment_end_i, force_axial_j, force_shear_j, moment_end_j,
    // stress_lower_fiber, stress_upper_fiber, zero pad
    output logic [fel_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: saturated
    output logic                            m_axis_tuser
);
    import fel_pkg::*;

    logic w_en;

    logic [E_W-1:0]     r_elastic;
    logic [A_W-1:0]     r_area;
    logic [I_W-1:0]     r_inertia;
    logic [C_W-1:0]     r_fiber;
    logic [MUL_A_W-1:0] r_ea;
    logic [MUL_A_W-1:0] r_ei;
    logic [C6_W-1:0]    r_c6;

    t_item  w_item;
    t_front w_front;
    t_front r_f5;
    t_front r_f6;
    t_side1 r_side1 [DIV_LAT];
    t_side2 r_s;
    t_side2 r_s8;
    t_side2 r_s9;
    t_side2 r_side2 [DIV_LAT];

    logic [MUL_P_W-1:0] w_p_ax, w_p_sh, w_p_mi, w_p_mj, w_p_t1, w_p_t2;
    logic [Q_W-1:0]     w_q_ax, w_q_sh, w_q_mi, w_q_mj, w_q_t1, w_q_t2;
    logic w_big_ax, w_big_sh, w_big_mi, w_big_mj, w_big_t1, w_big_t2;
    logic w_dz_ax, w_dz_sh, w_dz_mi, w_dz_mj, w_dz_t1, w_dz_t2;

    t_sat n_sat [NUM_RES];
    t_sat n_t1;
    t_sat n_t2;
    logic [RES_W-1:0] w_mag_r0;
    logic [RES_W-1:0] w_mag_r2;

    // Final stages
    logic                          r_t_valid;
    logic [TAG_W-1:0]              r_t_tag;
    logic [NUM_RES-1:0][RES_W-1:0] r_t_res;
    logic                          r_t_flag;
    logic [RES_W-1:0]              r_t1;
    logic [RES_W-1:0]              r_t2;
    logic                          r_o_valid;
    logic [TAG_W-1:0]              r_o_tag;
    logic [NUM_RES-1:0][RES_W-1:0] r_o_res;
    logic                          r_o_flag;
    logic [RES_W-1:0]              r_o_lower;
    logic [RES_W-1:0]              r_o_upper;

    logic signed [RES_W:0] n_lower;
    logic signed [RES_W:0] n_upper;
    logic                  n_lo_ovf;
    logic                  n_up_ovf;

    // The whole pipeline moves together whenever the output register is free.
    assign w_en          = !r_o_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elastic <= RST_ELASTIC;
            r_area    <= RST_AREA;
            r_inertia <= RST_INERTIA;
            r_fiber   <= RST_FIBER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ELASTIC: r_elastic <= i_cfg_data[E_W-1:0];
                REG_AREA:    r_area    <= i_cfg_data[A_W-1:0];
                REG_INERTIA: r_inertia <= i_cfg_data[I_W-1:0];
                REG_FIBER:   r_fiber   <= i_cfg_data[C_W-1:0];
                default: ;
            endcase
        end
    end

    // Products of the registers; these settle long before an item needs them.
    always_ff @(posedge i_clk) begin
        r_ea <= MUL_A_W'(r_elastic) * MUL_A_W'(r_area);
        r_ei <= MUL_A_W'(r_elastic) * MUL_A_W'(r_inertia);
        r_c6 <= C6_W'(r_fiber) * C6_W'(K_FIBER);
    end

    always_comb begin
        w_item.tag = s_axis_tdata[9:0];
        w_item.len = s_axis_tdata[33:10];
        w_item.ai  = s_axis_tdata[65:34];
        w_item.vi  = s_axis_tdata[97:66];
        w_item.ri  = s_axis_tdata[129:98];
        w_item.aj  = s_axis_tdata[161:130];
        w_item.vj  = s_axis_tdata[193:162];
        w_item.rj  = s_axis_tdata[225:194];
    end

    fel_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_item  (w_item),
        .o_front (w_front)
    );

    // Stiffness numerators
    fel_mul u_mul_ax (.i_clk(i_clk), .i_en(w_en), .i_a(r_ea),
                      .i_b(MUL_B_W'(w_front.mag_du)), .o_p(w_p_ax));
    fel_mul u_mul_sh (.i_clk(i_clk), .i_en(w_en), .i_a(r_ei),
                      .i_b(MUL_B_W'(w_front.mag_sh)), .o_p(w_p_sh));
    fel_mul u_mul_mi (.i_clk(i_clk), .i_en(w_en), .i_a(r_ei),
                      .i_b(MUL_B_W'(w_front.mag_mi)), .o_p(w_p_mi));
    fel_mul u_mul_mj (.i_clk(i_clk), .i_en(w_en), .i_a(r_ei),
                      .i_b(MUL_B_W'(w_front.mag_mj)), .o_p(w_p_mj));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f5.valid <= 1'b0;
            r_f6.valid <= 1'b0;
        end else if (w_en) begin
            r_f5 <= w_front;
            r_f6 <= r_f5;
        end
    end

    fel_div u_div_ax (.i_clk(i_clk), .i_en(w_en), .i_num(w_p_ax),
                      .i_den(DEN_W'(r_f6.dax)), .o_quo(w_q_ax), .o_big(w_big_ax),
                      .o_dz(w_dz_ax));
    fel_div u_div_sh (.i_clk(i_clk), .i_en(w_en), .i_num(w_p_sh),
                      .i_den(DEN_W'(r_f6.dsh)), .o_quo(w_q_sh), .o_big(w_big_sh),
                      .o_dz(w_dz_sh));
    fel_div u_div_mi (.i_clk(i_clk), .i_en(w_en), .i_num(w_p_mi),
                      .i_den(DEN_W'(r_f6.dmo)), .o_quo(w_q_mi), .o_big(w_big_mi),
                      .o_dz(w_dz_mi));
    fel_div u_div_mj (.i_clk(i_clk), .i_en(w_en), .i_num(w_p_mj),
                      .i_den(DEN_W'(r_f6.dmo)), .o_quo(w_q_mj), .o_big(w_big_mj),
                      .o_dz(w_dz_mj));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_side1[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_side1[0].valid  <= r_f6.valid;
            r_side1[0].tag    <= r_f6.tag;
            r_side1[0].neg_du <= r_f6.neg_du;
            r_side1[0].neg_sh <= r_f6.neg_sh;
            r_side1[0].neg_mi <= r_f6.neg_mi;
            r_side1[0].neg_mj <= r_f6.neg_mj;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side1[k] <= r_side1[k-1];
            end
        end
    end

    // The j-end axial and shear values share the i-end quotient with the
    // opposite sign; they clip separately since the range is asymmetric.
    always_comb begin
        n_sat[0] = sat_quo(w_q_ax, w_big_ax, w_dz_ax, r_side1[DIV_LAT-1].neg_du);
        n_sat[1] = sat_quo(w_q_sh, w_big_sh, w_dz_sh, r_side1[DIV_LAT-1].neg_sh);
        n_sat[2] = sat_quo(w_q_mi, w_big_mi, w_dz_mi, r_side1[DIV_LAT-1].neg_mi);
        n_sat[3] = sat_quo(w_q_ax, w_big_ax, w_dz_ax, !r_side1[DIV_LAT-1].neg_du);
        n_sat[4] = sat_quo(w_q_sh, w_big_sh, w_dz_sh, !r_side1[DIV_LAT-1].neg_sh);
        n_sat[5] = sat_quo(w_q_mj, w_big_mj, w_dz_mj, r_side1[DIV_LAT-1].neg_mj);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s.valid <= 1'b0;
        end else if (w_en) begin
            r_s.valid  <= r_side1[DIV_LAT-1].valid;
            r_s.tag    <= r_side1[DIV_LAT-1].tag;
            r_s.flag   <= n_sat[0].flag | n_sat[1].flag | n_sat[2].flag
                        | n_sat[3].flag | n_sat[4].flag | n_sat[5].flag;
            for (int k = 0; k < NUM_RES; k++) begin
                r_s.res[k] <= n_sat[k].val;
            end
            // Axial stress term is -N/A, so it is negative for positive N.
            r_s.neg_t1 <= !n_sat[0].val[RES_W-1];
            r_s.neg_t2 <= n_sat[2].val[RES_W-1];
        end
    end

    assign w_mag_r0 = r_s.res[0][RES_W-1] ? (RES_W'(0) - r_s.res[0]) : r_s.res[0];
    assign w_mag_r2 = r_s.res[2][RES_W-1] ? (RES_W'(0) - r_s.res[2]) : r_s.res[2];

    // Stress numerators
    fel_mul u_mul_t1 (.i_clk(i_clk), .i_en(w_en), .i_a(MUL_A_W'(w_mag_r0)),
                      .i_b(MUL_B_W'(K_MILLI)), .o_p(w_p_t1));
    fel_mul u_mul_t2 (.i_clk(i_clk), .i_en(w_en), .i_a(MUL_A_W'(w_mag_r2)),
                      .i_b(MUL_B_W'(r_c6)), .o_p(w_p_t2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8.valid <= 1'b0;
            r_s9.valid <= 1'b0;
        end else if (w_en) begin
            r_s8 <= r_s;
            r_s9 <= r_s8;
        end
    end

    fel_div u_div_t1 (.i_clk(i_clk), .i_en(w_en), .i_num(w_p_t1),
                      .i_den(DEN_W'(r_area)), .o_quo(w_q_t1), .o_big(w_big_t1),
                      .o_dz(w_dz_t1));
    fel_div u_div_t2 (.i_clk(i_clk), .i_en(w_en), .i_num(w_p_t2),
                      .i_den(DEN_W'(r_inertia)), .o_quo(w_q_t2), .o_big(w_big_t2),
                      .o_dz(w_dz_t2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_side2[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_side2[0] <= r_s9;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side2[k] <= r_side2[k-1];
            end
        end
    end

    always_comb begin
        n_t1 = sat_quo(w_q_t1, w_big_t1, w_dz_t1, r_side2[DIV_LAT-1].neg_t1);
        n_t2 = sat_quo(w_q_t2, w_big_t2, w_dz_t2, r_side2[DIV_LAT-1].neg_t2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (w_en) begin
            r_t_valid <= r_side2[DIV_LAT-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_tag  <= r_side2[DIV_LAT-1].tag;
            r_t_res  <= r_side2[DIV_LAT-1].res;
            r_t_flag <= r_side2[DIV_LAT-1].flag | n_t1.flag | n_t2.flag;
            r_t1     <= n_t1.val;
            r_t2     <= n_t2.val;
        end
    end

    // Stress sums carry one extra bit; the top two bits differ on overflow.
    always_comb begin
        n_lower  = $signed({r_t1[RES_W-1], r_t1}) - $signed({r_t2[RES_W-1], r_t2});
        n_upper  = $signed({r_t1[RES_W-1], r_t1}) + $signed({r_t2[RES_W-1], r_t2});
        n_lo_ovf = n_lower[RES_W] ^ n_lower[RES_W-1];
        n_up_ovf = n_upper[RES_W] ^ n_upper[RES_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_tag   <= r_t_tag;
            r_o_res   <= r_t_res;
            r_o_flag  <= r_t_flag | n_lo_ovf | n_up_ovf;
            r_o_lower <= n_lo_ovf ? (n_lower[RES_W] ? SAT_LO : SAT_HI)
                                  : n_lower[RES_W-1:0];
            r_o_upper <= n_up_ovf ? (n_upper[RES_W] ? SAT_LO : SAT_HI)
                                  : n_upper[RES_W-1:0];
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_flag;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_o_upper, r_o_lower,
                            r_o_res[5], r_o_res[4], r_o_res[3],
                            r_o_res[2], r_o_res[1], r_o_res[0], r_o_tag};

endmodule
